// ===== hdl/slow_drift_lowpass_rk4_macros.svh =====
// Assertion macros shared by the slow-drift low-pass tracker.
`ifndef SLOW_DRIFT_LOWPASS_RK4_MACROS_SVH
`define SLOW_DRIFT_LOWPASS_RK4_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SDL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define SDL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/sdl_pkg.sv =====
// Types, constants and arithmetic helpers of the slow-drift low-pass tracker.
package sdl_pkg;

    localparam int AXIS_SLOTS = 6;
    localparam int AXS_W      = 3;
    localparam int WORD_W     = 32;
    localparam int SET_FRAC   = 24;
    localparam int DEF_AXES   = 6;
    localparam int DIV_W      = 36;
    localparam int DIV_STEPS  = DIV_W / 4;

    localparam logic [31:0] RST_CUTOFF  = 32'd0;
    localparam logic [31:0] RST_DAMPING = 32'd3355443;
    localparam logic [31:0] RST_STEP    = 32'd1677722;

    typedef enum logic [1:0] {
        REG_CUTOFF  = 2'd0,
        REG_DAMPING = 2'd1,
        REG_STEP    = 2'd2
    } t_reg_idx;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef struct packed {
        t_word pos_surge;
        t_word pos_sway;
        t_word pos_heave;
        t_word pos_roll;
        t_word pos_pitch;
        t_word pos_yaw;
    } t_in;

    typedef struct packed {
        t_word drift_surge;
        t_word drift_sway;
        t_word drift_heave;
        t_word drift_roll;
        t_word drift_pitch;
        t_word drift_yaw;
        t_word rate_surge;
        t_word rate_sway;
        t_word rate_heave;
        t_word rate_roll;
        t_word rate_pitch;
        t_word rate_yaw;
    } t_out;

    function automatic t_word sat32(input logic signed [41:0] x);
        t_word r;
        if (x > 42'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -42'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

    function automatic t_word in_pos(input t_in d, input logic [AXS_W-1:0] ax);
        t_word r;
        case (ax)
            3'd0:    r = d.pos_surge;
            3'd1:    r = d.pos_sway;
            3'd2:    r = d.pos_heave;
            3'd3:    r = d.pos_roll;
            3'd4:    r = d.pos_pitch;
            3'd5:    r = d.pos_yaw;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_out pack_out(input t_word dx [AXIS_SLOTS],
                                      input t_word dv [AXIS_SLOTS]);
        t_out r;
        r.drift_surge = dx[0];
        r.drift_sway  = dx[1];
        r.drift_heave = dx[2];
        r.drift_roll  = dx[3];
        r.drift_pitch = dx[4];
        r.drift_yaw   = dx[5];
        r.rate_surge  = dv[0];
        r.rate_sway   = dv[1];
        r.rate_heave  = dv[2];
        r.rate_roll   = dv[3];
        r.rate_pitch  = dv[4];
        r.rate_yaw    = dv[5];
        return r;
    endfunction

endpackage

// ===== hdl/sdl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module sdl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/sdl_div6.sv =====
// Floor division of an unsigned word by six, one hex digit per cycle.
module sdl_div6 import sdl_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_num,
    output logic [DIV_W-1:0] o_quot,
    output logic             o_done
);

    localparam int CW = $clog2(DIV_STEPS + 1);
    localparam logic [12:0] RECIP = 13'd43;
    localparam logic [6:0]  DVSR  = 7'd6;

    logic [DIV_W-1:0] r_num;
    logic [DIV_W-1:0] r_quot;
    logic [2:0]       r_rem;
    logic [CW-1:0]    r_cnt;
    logic             r_done;

    logic [6:0]  w_n;
    logic [12:0] w_m;
    logic [3:0]  w_qd;
    logic [6:0]  w_r;

    // The partial remainder is below 96, where n*43/256 gives the exact digit.
    always_comb begin
        w_n  = {r_rem, r_num[DIV_W-1 -: 4]};
        w_m  = 13'(w_n) * RECIP;
        w_qd = w_m[11:8];
        w_r  = w_n - 7'(w_qd) * DVSR;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_num  <= i_num;
                r_quot <= '0;
                r_rem  <= '0;
                r_cnt  <= CW'(DIV_STEPS);
            end else if (r_cnt != '0) begin
                r_num  <= {r_num[DIV_W-5:0], 4'd0};
                r_quot <= {r_quot[DIV_W-5:0], w_qd};
                r_rem  <= w_r[2:0];
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_quot;
    assign o_done = r_done;

endmodule

// ===== hdl/slow_drift_lowpass_rk4.sv =====
// Takes one input item at a time: o_ready is high only while idle, so a new item waits
// until the result of the last one has been loaded into the output register.
// With a positive cutoff each axis runs 16 products through the one shared 32x33
// multiplier and two nine-step divides by six, with the state in one axis-wide RAM.
// Reset (synchronous, active low) clears the state valid bits, so all state reads as zero,
// restores the register defaults and empties the output register.
module slow_drift_lowpass_rk4 import sdl_pkg::*; #(
    parameter int NUM_AXES = DEF_AXES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);

    `include "slow_drift_lowpass_rk4_macros.svh"

    localparam int AXW  = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int MEMW = 3 * WORD_W;
    localparam logic [DIV_W-1:0] DIV_OFS = DIV_W'(6) << 33;
    localparam logic signed [41:0] QUOT_OFS = 42'sd8589934592;

    typedef enum logic [4:0] {
        ST_IDLE, ST_C1, ST_C2, ST_C3, ST_RD, ST_LD,
        ST_S0, ST_S1, ST_S2, ST_S3, ST_S4, ST_DI, ST_DV, ST_WB, ST_DONE
    } t_state;

    t_state r_state;

    logic [31:0] r_cutoff, r_damp, r_dt;
    logic [31:0] r_c1, r_c2;
    logic        r_en;
    t_in         r_in;
    logic [AXW-1:0] r_ax;
    logic [1:0]  r_stg;
    logic [NUM_AXES-1:0] r_vld;
    t_word r_x, r_v, r_p, r_np, r_mid, r_tv, r_tx, r_err, r_m1, r_a, r_xk;
    logic signed [34:0] r_sumv, r_sumx;
    logic signed [64:0] r_prod;
    t_word r_res_x [AXIS_SLOTS];
    t_word r_res_v [AXIS_SLOTS];
    logic  r_ovalid;
    t_out  r_out;

    t_word             mul_a;
    logic [31:0]       mul_b;
    logic signed [64:0] w_prod;
    t_word             w_pq;
    logic [39:0]       w_cf;
    t_word             w_tgt;
    logic              w_dbl;
    t_word             w_inc_v, w_inc_x;
    logic signed [34:0] w_addv, w_addx;
    t_word             n_tv, n_tx;
    t_word             n_x, n_v;
    logic [MEMW-1:0]   w_rdata, w_wdata;
    logic              w_we;
    logic              w_div_start;
    logic [DIV_W-1:0]  w_qv, w_qx;
    logic              w_vdone, w_xdone;
    t_word             w_dx [AXIS_SLOTS];
    t_word             w_dv [AXIS_SLOTS];
    logic              w_in_xfer;

    assign o_ready   = (r_state == ST_IDLE);
    assign w_in_xfer = i_valid && o_ready;

    // Shared multiplier: signed value times unsigned Q8.24 setting.
    always_comb begin
        case (r_state)
            ST_C1:   begin mul_a = r_cutoff; mul_b = r_damp;   end
            ST_C2:   begin mul_a = r_cutoff; mul_b = r_cutoff; end
            ST_S0:   begin mul_a = r_tv;     mul_b = r_c1;     end
            ST_S1:   begin mul_a = r_err;    mul_b = r_c2;     end
            ST_S2:   begin mul_a = r_tv;     mul_b = r_dt;     end
            ST_S3:   begin mul_a = r_a;      mul_b = r_dt;     end
            default: begin mul_a = r_tv;     mul_b = r_dt;     end
        endcase
        w_prod = mul_a * $signed({1'b0, mul_b});
        w_pq   = sat32(42'($signed(r_prod[64:24])));
        w_cf   = r_prod[63:24];
    end

    always_comb begin
        case (r_stg)
            2'd0:    w_tgt = r_p;
            2'd3:    w_tgt = r_np;
            default: w_tgt = r_mid;
        endcase
        w_dbl   = (r_stg == 2'd1) || (r_stg == 2'd2);
        w_inc_v = (r_stg == 2'd2) ? w_pq : (w_pq >>> 1);
        w_inc_x = (r_stg == 2'd2) ? r_xk : (r_xk >>> 1);
        n_tv    = sat32(42'(r_v) + 42'(w_inc_v));
        n_tx    = sat32(42'(r_x) + 42'(w_inc_x));
        w_addv  = w_dbl ? 35'($signed({w_pq, 1'b0})) : 35'(w_pq);
        w_addx  = w_dbl ? 35'($signed({r_xk, 1'b0})) : 35'(r_xk);
    end

    // Quotients carry an offset of 2^33 that made the dividend non-negative.
    always_comb begin
        if (r_en) begin
            n_v = sat32(42'(r_v) + 42'($signed({1'b0, w_qv})) - QUOT_OFS);
            n_x = sat32(42'(r_x) + 42'($signed({1'b0, w_qx})) - QUOT_OFS);
        end else begin
            n_v = r_v;
            n_x = r_x;
        end
        w_wdata     = {r_np, n_x, n_v};
        w_we        = (r_state == ST_WB);
        w_div_start = (r_state == ST_DI);
    end

    always_comb begin
        for (int i = 0; i < AXIS_SLOTS; i++) begin
            if (i < NUM_AXES) begin
                w_dx[i] = r_res_x[i];
                w_dv[i] = r_res_v[i];
            end else begin
                w_dx[i] = '0;
                w_dv[i] = '0;
            end
        end
    end

    sdl_ram #(
        .WIDTH (MEMW),
        .DEPTH (NUM_AXES),
        .AW    (AXW)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_ax),
        .i_wdata (w_wdata),
        .i_raddr (r_ax),
        .o_rdata (w_rdata)
    );

    sdl_div6 u_div_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (DIV_W'(r_sumv) + DIV_OFS),
        .o_quot  (w_qv),
        .o_done  (w_vdone)
    );

    sdl_div6 u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (DIV_W'(r_sumx) + DIV_OFS),
        .o_quot  (w_qx),
        .o_done  (w_xdone)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cutoff <= RST_CUTOFF;
            r_damp   <= RST_DAMPING;
            r_dt     <= RST_STEP;
            r_vld    <= '0;
            r_ovalid <= 1'b0;
            r_ax     <= '0;
            r_stg    <= '0;
            r_en     <= 1'b0;
        end else begin
            r_prod <= w_prod;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CUTOFF:  r_cutoff <= i_cfg_wdata;
                    REG_DAMPING: r_damp   <= i_cfg_wdata;
                    REG_STEP:    r_dt     <= i_cfg_wdata;
                    default:     ;
                endcase
            end
            if (r_ovalid && i_ready && (r_state != ST_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_xfer) begin
                        r_in <= i_data;
                        r_ax <= '0;
                        r_en <= ($signed(r_cutoff) > 32'sd0);
                        r_state <= ($signed(r_cutoff) > 32'sd0) ? ST_C1 : ST_RD;
                    end
                end
                ST_C1: r_state <= ST_C2;
                ST_C2: begin
                    // c1 is twice the floored product, clamped to the unsigned range.
                    r_c1 <= (w_cf[39:31] != '0) ? 32'hFFFF_FFFF : {w_cf[30:0], 1'b0};
                    r_state <= ST_C3;
                end
                ST_C3: begin
                    r_c2 <= (w_cf[39:32] != '0) ? 32'hFFFF_FFFF : w_cf[31:0];
                    r_state <= ST_RD;
                end
                ST_RD: r_state <= ST_LD;
                ST_LD: begin
                    if (r_vld[r_ax]) begin
                        r_p  <= w_rdata[3*WORD_W-1 -: WORD_W];
                        r_x  <= w_rdata[2*WORD_W-1 -: WORD_W];
                        r_v  <= w_rdata[WORD_W-1:0];
                        r_tx <= w_rdata[2*WORD_W-1 -: WORD_W];
                        r_tv <= w_rdata[WORD_W-1:0];
                        r_mid <= 32'(33'(t_word'(w_rdata[3*WORD_W-1 -: WORD_W]))
                               + ((33'(in_pos(r_in, AXS_W'(r_ax)))
                                 - 33'(t_word'(w_rdata[3*WORD_W-1 -: WORD_W]))) >>> 1));
                    end else begin
                        r_p  <= '0;
                        r_x  <= '0;
                        r_v  <= '0;
                        r_tx <= '0;
                        r_tv <= '0;
                        r_mid <= 32'((33'(in_pos(r_in, AXS_W'(r_ax)))) >>> 1);
                    end
                    r_np  <= in_pos(r_in, AXS_W'(r_ax));
                    r_stg <= '0;
                    r_state <= r_en ? ST_S0 : ST_WB;
                end
                ST_S0: begin
                    r_err <= sat32(42'(r_tx) - 42'(w_tgt));
                    r_state <= ST_S1;
                end
                ST_S1: begin
                    r_m1 <= w_pq;
                    r_state <= ST_S2;
                end
                ST_S2: begin
                    r_a <= sat32(-42'(r_m1) - 42'(w_pq));
                    r_state <= ST_S3;
                end
                ST_S3: begin
                    r_xk <= w_pq;
                    r_state <= ST_S4;
                end
                ST_S4: begin
                    if (r_stg == 2'd0) begin
                        r_sumv <= w_addv;
                        r_sumx <= w_addx;
                    end else begin
                        r_sumv <= r_sumv + w_addv;
                        r_sumx <= r_sumx + w_addx;
                    end
                    r_tv <= n_tv;
                    r_tx <= n_tx;
                    if (r_stg == 2'd3) begin
                        r_state <= ST_DI;
                    end else begin
                        r_stg <= r_stg + 2'd1;
                        r_state <= ST_S0;
                    end
                end
                ST_DI: r_state <= ST_DV;
                ST_DV: begin
                    if (w_vdone) begin
                        r_state <= ST_WB;
                    end
                end
                ST_WB: begin
                    r_vld[r_ax] <= 1'b1;
                    r_res_x[3'(r_ax)] <= n_x;
                    r_res_v[3'(r_ax)] <= n_v;
                    if (r_ax == AXW'(NUM_AXES - 1)) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_ax <= r_ax + 1'b1;
                        r_state <= ST_RD;
                    end
                end
                ST_DONE: begin
                    if (!r_ovalid || i_ready) begin
                        r_out    <= pack_out(w_dx, w_dv);
                        r_ovalid <= 1'b1;
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    `SDL_ASSERT_NXT(a_busy_after_xfer, w_in_xfer, r_state != ST_IDLE)
    `SDL_ASSERT_IMP(a_div_pair, 1'b1, w_vdone == w_xdone)
    `SDL_ASSERT_IMP(a_div_in_wait, w_vdone, r_state == ST_DV)
    `SDL_ASSERT_IMP(a_axis_range, r_state == ST_RD, r_ax <= AXW'(NUM_AXES - 1))

endmodule

// ===== tb/slow_drift_lowpass_rk4_tb.sv =====
// Self-checking testbench for the slow-drift RK4 low-pass tracker.
module slow_drift_lowpass_rk4_tb import sdl_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    // Predicts the tracker state per transfer and checks each result against it.
    class drift_scoreboard;
        logic signed [31:0] cutoff;
        logic [31:0] damping;
        logic [31:0] dt;
        longint prev_pos [AXIS_SLOTS];
        longint drift_x [AXIS_SLOTS];
        longint drift_v [AXIS_SLOTS];
        t_out pending [$];
        int errors;

        function void clear();
            cutoff = RST_CUTOFF;
            damping = RST_DAMPING;
            dt = RST_STEP;
            foreach (prev_pos[i]) begin
                prev_pos[i] = 0;
                drift_x[i] = 0;
                drift_v[i] = 0;
            end
            pending.delete();
            errors = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [31:0] val);
            case (idx)
                REG_CUTOFF:  cutoff = val;
                REG_DAMPING: damping = val;
                REG_STEP:    dt = val;
                default: ;
            endcase
        endfunction

        function longint clip(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        function longint floor_div(longint x, longint d);
            if (x >= 0) return x / d;
            return -(((-x) + d - 1) / d);
        endfunction

        function longint scale(longint a, longint s);
            return clip(floor_div(a * s, 64'sd16777216));
        endfunction

        function longint accel(longint v, longint x, longint tgt, longint c1, longint c2);
            return clip(-scale(v, c1) - scale(clip(x - tgt), c2));
        endfunction

        function longint coef_clip(longint x);
            if (x > 64'sd4294967295) return 64'sd4294967295;
            if (x < 0) return 0;
            return x;
        endfunction

        function void rk4_axis(int ax, longint newp, longint c1, longint c2);
            longint x, v, p, mid, s, tv, tx;
            longint a1, v1, x1, a2, v2, x2, a3, v3, x3, a4, v4, x4;
            x = drift_x[ax];
            v = drift_v[ax];
            p = prev_pos[ax];
            s = dt;
            mid = p + floor_div(newp - p, 2);
            a1 = accel(v, x, p, c1, c2);
            v1 = scale(a1, s);
            x1 = scale(v, s);
            tv = clip(v + floor_div(v1, 2));
            tx = clip(x + floor_div(x1, 2));
            a2 = accel(tv, tx, mid, c1, c2);
            v2 = scale(a2, s);
            x2 = scale(tv, s);
            tv = clip(v + floor_div(v2, 2));
            tx = clip(x + floor_div(x2, 2));
            a3 = accel(tv, tx, mid, c1, c2);
            v3 = scale(a3, s);
            x3 = scale(tv, s);
            tv = clip(v + v3);
            tx = clip(x + x3);
            a4 = accel(tv, tx, newp, c1, c2);
            v4 = scale(a4, s);
            x4 = scale(tv, s);
            drift_v[ax] = clip(v + floor_div(v1 + 2 * v2 + 2 * v3 + v4, 6));
            drift_x[ax] = clip(x + floor_div(x1 + 2 * x2 + 2 * x3 + x4, 6));
        endfunction

        function void note_input(t_in d);
            longint w, c1, c2, np;
            t_word dx [AXIS_SLOTS];
            t_word dv [AXIS_SLOTS];
            w = cutoff;
            c1 = coef_clip(2 * floor_div(w * longint'(damping), 64'sd16777216));
            c2 = coef_clip(floor_div(w * w, 64'sd16777216));
            for (int i = 0; i < AXIS_SLOTS; i++) begin
                np = in_pos(d, i[2:0]);
                if (w > 0) rk4_axis(i, np, c1, c2);
                prev_pos[i] = np;
                dx[i] = drift_x[i][31:0];
                dv[i] = drift_v[i][31:0];
            end
            pending.push_back(pack_out(dx, dv));
        endfunction

        function void check_result(t_out got);
            t_out exp_r;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            for (int i = 0; i < 12; i++) begin
                if (exp_r[383 - 32*i -: 32] !== got[383 - 32*i -: 32]) begin
                    $display("%0t: field %0d expected %h actual %h", $realtime, i,
                             exp_r[383 - 32*i -: 32], got[383 - 32*i -: 32]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_ready;
    t_in i_data = '0;
    logic o_valid;
    logic i_ready = 0;
    t_out o_data;
    logic i_cfg_we = 0;
    logic [1:0] i_cfg_idx = '0;
    logic [31:0] i_cfg_wdata = '0;

    drift_scoreboard sb;
    bit calm;
    int quiet_cycles;

    always #4 i_clk = ~i_clk;

    slow_drift_lowpass_rk4 dut (.*);

    // Receiver side: random stall bursts, checked at each result transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_data);
    end

    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || calm) begin
                i_ready <= 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else if ($urandom_range(0, 3) == 0) begin
                hold = $urandom_range(0, 17);
                i_ready <= ~i_ready;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("slow_drift_lowpass_rk4: mismatch");
            $finish;
        end
    end

    task automatic send_item(t_in d);
        if (!calm && $urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= d;
        do @(posedge i_clk); while (!o_ready);
        sb.note_input(d);
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_reg_idx idx, logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.write_reg(idx, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_word rand_word(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 65535) - 32768;
            2: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
            default: return $urandom();
        endcase
    endfunction

    function automatic t_in rand_item(int mode);
        t_in d;
        d.pos_surge = rand_word(mode);
        d.pos_sway  = rand_word(mode);
        d.pos_heave = rand_word(mode);
        d.pos_roll  = rand_word(mode);
        d.pos_pitch = rand_word(mode);
        d.pos_yaw   = rand_word(mode);
        return d;
    endfunction

    initial begin
        logic [31:0] cut_set [8];
        logic [31:0] damp_set [6];
        logic [31:0] step_set [6];
        sb = new();
        sb.clear();
        calm = 0;
        quiet_cycles = 0;
        cut_set = '{32'h0100_0000, 32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                    32'h0000_0000, 32'h0400_0000, 32'h0064_0000, 32'hFFFF_FFFF};
        damp_set = '{32'd3355443, 32'h0, 32'hFFFF_FFFF, 32'h0100_0000,
                     32'h0080_0000, 32'h0200_0000};
        step_set = '{32'd1677722, 32'h0, 32'hFFFF_FFFF, 32'h0010_0000,
                     32'h0100_0000, 32'h0000_0001};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset cutoff holds the state, then extremes with filtering on.
        send_item('{default: 32'sh7FFF_FFFF});
        send_item('{default: 32'sh8000_0000});
        wait_drained();
        write_cfg(REG_CUTOFF, 32'h0100_0000);
        send_item('{default: 32'sh7FFF_FFFF});
        send_item('{default: 32'sh8000_0000});
        send_item('{default: '0});
        send_item('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0001_0000, -32'sh0001_0000,
                    32'sh5555_5555, 32'shAAAA_AAAA});
        wait_drained();
        write_cfg(REG_CUTOFF, 32'h7FFF_FFFF);
        write_cfg(REG_DAMPING, 32'hFFFF_FFFF);
        write_cfg(REG_STEP, 32'hFFFF_FFFF);
        for (int k = 0; k < 6; k++) send_item(rand_item(k % 3));
        wait_drained();
        // Register index outside the list must leave the settings untouched.
        i_cfg_we <= 1'b1;
        i_cfg_idx <= 2'd3;
        i_cfg_wdata <= $urandom();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        write_cfg(REG_CUTOFF, 32'h8000_0000);
        for (int k = 0; k < 3; k++) send_item(rand_item(0));
        wait_drained();

        // Random phases, each under its own settings; the last three phases run without idling.
        for (int ph = 0; ph < 25; ph++) begin
            if (ph == 22) calm = 1;
            write_cfg(REG_CUTOFF, ($urandom_range(0, 4) == 0) ? $urandom()
                                                                : cut_set[$urandom_range(0, 7)]);
            write_cfg(REG_DAMPING, ($urandom_range(0, 3) == 0) ? $urandom()
                                                                : damp_set[$urandom_range(0, 5)]);
            write_cfg(REG_STEP, ($urandom_range(0, 3) == 0) ? $urandom()
                                                             : step_set[$urandom_range(0, 5)]);
            for (int k = 0; k < 49; k++) begin
                send_item(rand_item($urandom_range(0, 3)));
                // Sender holds off until the block has delivered everything.
                if (k == 20 && ph == 3) wait_drained();
            end
            wait_drained();
        end

        repeat (300) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("slow_drift_lowpass_rk4: match");
        end else begin
            $display("slow_drift_lowpass_rk4: mismatch");
        end
        $finish;
    end
endmodule
